// File: src/uetp_pkg.sv
// Package for the ultrasonic echo to tone period block.
// Holds the phase and result types, register indexes and mapping constants.
// Depends on nothing.
package uetp_pkg;

    localparam int unsigned TICK_W    = 16;
    localparam int unsigned HP_W      = 8;
    localparam int unsigned THR_W     = 20;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned N_THR     = 7;

    typedef enum logic {
        PH_TRIGGER = 1'b0,
        PH_LISTEN  = 1'b1
    } t_phase;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_TICKS  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_BASE     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_STEP     = 4'd3;

    localparam logic [TICK_W-1:0] TRIGGER_TICKS_RST = 16'd20;
    localparam logic [TICK_W-1:0] LISTEN_TICKS_RST  = 16'd45000;
    localparam logic [TICK_W-1:0] NOTE_BASE_RST     = 16'd600;
    localparam logic [TICK_W-1:0] NOTE_STEP_RST     = 16'd400;

    // Step multiples for the ladder thresholds; the second step is skipped.
    localparam logic [2:0] LADDER_MULT [N_THR] = '{3'd0, 3'd1, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};

    // Half-period for each ladder rung, the last one for widths above all thresholds.
    localparam logic [HP_W-1:0] LADDER_TONE [N_THR+1] =
        '{8'd119, 8'd105, 8'd94, 8'd88, 8'd79, 8'd70, 8'd62, 8'd59};

    localparam logic [HP_W-1:0] TONE_CMP_RST = 8'd59;

    // Division by 60 as a multiply by ceil(2^22/60); exact for all 16-bit widths.
    localparam logic [16:0] DIV60_RECIP = 17'd69906;
    localparam int unsigned DIV60_SHIFT = 22;
    localparam int unsigned PROD_W      = TICK_W + 17;
    localparam int unsigned QUOT_W      = PROD_W - DIV60_SHIFT;
    localparam logic [QUOT_W:0] LIN_OFFSET = 12'd100;
    localparam logic [QUOT_W:0] LIN_MAX    = 12'd255;

    typedef struct packed {
        logic              trigger_out;
        logic              width_valid;
        logic [TICK_W-1:0] echo_width;
        logic [HP_W-1:0]   tone_cmp;
    } t_result;

endpackage

// File: src/ultrasonic_echo_to_tone_period.sv
// Ultrasonic echo ranging controller that turns echo widths into a tone half-period.
// Accepted ticks enter the input register, then their result items go to the output
// register, or to the skid when it is stalled. One tick per cycle unless held off.
// The input is held off only while a tick waits and the output register and skid are full.
// Reset: synchronous, active low; registers return to their reset values and the
// block starts in the trigger phase with a half-period of 59.
module ultrasonic_echo_to_tone_period (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Tick items in
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_echo_level,
    input  logic                             i_discrete_mode,
    // Result items out
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_trigger_out,
    output logic                             o_width_valid,
    output logic [uetp_pkg::TICK_W-1:0]      o_echo_width,
    output logic [uetp_pkg::HP_W-1:0]        o_tone_cmp,
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [uetp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [uetp_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import uetp_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; an index
    // beyond the register list is dropped.
    // ------------------------------------------------------------------
    logic [TICK_W-1:0] r_trigger_ticks;
    logic [TICK_W-1:0] r_listen_ticks;
    logic [TICK_W-1:0] r_note_base;
    logic [TICK_W-1:0] r_note_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= TRIGGER_TICKS_RST;
            r_listen_ticks  <= LISTEN_TICKS_RST;
            r_note_base     <= NOTE_BASE_RST;
            r_note_step     <= NOTE_STEP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TRIGGER_TICKS: r_trigger_ticks <= i_cfg_data;
                CFG_LISTEN_TICKS:  r_listen_ticks  <= i_cfg_data;
                CFG_NOTE_BASE:     r_note_base     <= i_cfg_data;
                CFG_NOTE_STEP:     r_note_step     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Ladder thresholds follow the configuration directly. They are exact
    // (20 bits, no wrap); each multiple is a constant, so this is shifts and adds.
    logic [THR_W-1:0] thr [N_THR];

    always_comb begin
        for (int k = 0; k < N_THR; k++) begin
            thr[k] = THR_W'(r_note_base) + THR_W'(r_note_step) * THR_W'(LADDER_MULT[k]);
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register feeds the update logic, which fires
    // when it holds a tick and the skid register is empty: the result then
    // lands either in the output register or, if that is full and stalled,
    // in the skid.
    logic    r_in_vld;
    logic    r_echo;
    logic    r_disc;
    logic    r_o_vld;
    t_result r_o;
    logic    r_s_vld;
    t_result r_s;

    logic    fire;
    logic    in_acc;
    logic    out_free;
    t_result res;

    assign fire     = r_in_vld && !r_s_vld;
    assign o_stall  = r_in_vld && r_s_vld;
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_o_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_echo <= i_echo_level;
            r_disc <= i_discrete_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else begin
            if (out_free) begin
                r_o_vld <= r_s_vld || fire;
                r_s_vld <= 1'b0;
            end else if (fire) begin
                r_s_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_o <= r_s_vld ? r_s : res;
        end else if (fire) begin
            r_s <= res;
        end
    end

    assign o_valid       = r_o_vld;
    assign o_trigger_out = r_o.trigger_out;
    assign o_width_valid = r_o.width_valid;
    assign o_echo_width  = r_o.echo_width;
    assign o_tone_cmp    = r_o.tone_cmp;

    // ------------------------------------------------------------------
    // Ranging state. Updated once for each item that fires.
    // ------------------------------------------------------------------
    t_phase            r_phase;
    logic [TICK_W-1:0] r_phase_ticks;
    logic [TICK_W-1:0] r_high_ticks;
    logic              r_seen_high;
    logic              r_prev_echo;
    logic [HP_W-1:0]   r_tone;
    logic [TICK_W-1:0] r_last_width;

    t_phase            n_phase;
    logic [TICK_W-1:0] n_phase_ticks;
    logic [TICK_W-1:0] n_high_ticks;
    logic              n_seen_high;
    logic              n_tone_sel;
    logic [TICK_W-1:0] n_last_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TRIGGER;
            r_phase_ticks <= '0;
            r_high_ticks  <= '0;
            r_seen_high   <= 1'b0;
            r_prev_echo   <= 1'b0;
            r_tone        <= TONE_CMP_RST;
            r_last_width  <= '0;
        end else if (fire) begin
            r_phase       <= n_phase;
            r_phase_ticks <= n_phase_ticks;
            r_high_ticks  <= n_high_ticks;
            r_seen_high   <= n_seen_high;
            r_prev_echo   <= r_echo;
            r_tone        <= res.tone_cmp;
            r_last_width  <= n_last_width;
        end
    end

    // Width of an echo that completes on this tick.
    logic [TICK_W-1:0] high_inc;
    logic [TICK_W-1:0] phase_inc;
    assign high_inc  = r_high_ticks + 1'b1;
    assign phase_inc = r_phase_ticks + 1'b1;

    // Continuous mapping: width/60 + 100, saturated at 255.
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    logic [QUOT_W:0]   lin_sum;
    logic [HP_W-1:0]   lin_tone;

    assign prod     = PROD_W'(high_inc) * PROD_W'(DIV60_RECIP);
    assign quot     = prod[PROD_W-1:DIV60_SHIFT];
    assign lin_sum  = {1'b0, quot} + LIN_OFFSET;
    assign lin_tone = (lin_sum > LIN_MAX) ? HP_W'(LIN_MAX) : lin_sum[HP_W-1:0];

    // Note ladder: the lowest threshold that the width stays below picks the rung.
    logic [HP_W-1:0] ladder_tone;

    always_comb begin
        ladder_tone = LADDER_TONE[N_THR];
        for (int k = N_THR - 1; k >= 0; k--) begin
            if (THR_W'(high_inc) < thr[k]) begin
                ladder_tone = LADDER_TONE[k];
            end
        end
    end

    // Next state and the result of this tick.
    always_comb begin
        n_phase       = r_phase;
        n_phase_ticks = phase_inc;
        n_high_ticks  = r_high_ticks;
        n_seen_high   = r_seen_high;
        n_tone_sel    = 1'b0;
        n_last_width  = r_last_width;
        res.trigger_out = 1'b0;
        res.width_valid = 1'b0;

        unique case (r_phase)
            PH_LISTEN: begin
                if (r_echo && !r_prev_echo && !r_seen_high) begin
                    // Rising edge: start timing the echo.
                    n_seen_high  = 1'b1;
                    n_high_ticks = '0;
                end else if (r_seen_high) begin
                    n_high_ticks = high_inc;
                    if (!r_echo && r_prev_echo) begin
                        // Falling edge: the width is complete, retrigger.
                        res.width_valid = 1'b1;
                        n_last_width    = high_inc;
                        n_tone_sel      = 1'b1;
                        n_seen_high     = 1'b0;
                        n_phase         = PH_TRIGGER;
                        n_phase_ticks   = '0;
                    end
                end
                // Listen window over without a complete echo: drop any partial width.
                if (!res.width_valid && phase_inc >= r_listen_ticks) begin
                    n_seen_high   = 1'b0;
                    n_phase       = PH_TRIGGER;
                    n_phase_ticks = '0;
                end
            end
            PH_TRIGGER: begin
                res.trigger_out = 1'b1;
                if (phase_inc >= r_trigger_ticks) begin
                    n_phase       = PH_LISTEN;
                    n_phase_ticks = '0;
                    n_seen_high   = 1'b0;
                end
            end
            default: begin
                res.trigger_out = 1'b1;
            end
        endcase

        res.echo_width = n_last_width;
        res.tone_cmp   = n_tone_sel ? (r_disc ? ladder_tone : lin_tone) : r_tone;
    end

endmodule

// File: src/uetp_checker.sv
// Port-level checks for the ultrasonic echo to tone period block.
// Depends on uetp_pkg and on ultrasonic_echo_to_tone_period, to which it is bound.
module uetp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic                           o_trigger_out,
    input logic                           o_width_valid,
    input logic [uetp_pkg::TICK_W-1:0]    o_echo_width,
    input logic [uetp_pkg::HP_W-1:0]      o_tone_cmp
);

    // Input is only held off when both output slots are occupied.
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while the output register is empty");

    // A width can only complete during the listen phase.
    a_width_not_in_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_width_valid) |-> !o_trigger_out)
        else $error("width reported on a trigger tick");

    // A stalled result item holds its payload.
    a_stalled_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_echo_width)
                                  && $stable(o_tone_cmp)
                                  && $stable(o_trigger_out)
                                  && $stable(o_width_valid)))
        else $error("stalled result item changed");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("items left in flight after reset");

endmodule

bind ultrasonic_echo_to_tone_period uetp_checker u_uetp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_trigger_out (o_trigger_out),
    .o_width_valid (o_width_valid),
    .o_echo_width  (o_echo_width),
    .o_tone_cmp    (o_tone_cmp)
);
